// ----- src/otwg_pkg.sv -----
// Shared types, register indexes, status codes and defaults for the tile window generator.
package otwg_pkg;

  localparam int DIM_WIDTH_DEF = 16;
  localparam int WIN_WIDTH_DEF = 8;
  localparam int REG_INDEX_WIDTH = 3;

  localparam int BAND_WIDTH_RESET     = 1024;
  localparam int BAND_HEIGHT_RESET    = 1024;
  localparam int TILE_WIDTH_RESET     = 256;
  localparam int TILE_HEIGHT_RESET    = 256;
  localparam int WINDOW_RANGE_RESET   = 15;
  localparam int WINDOW_AZIMUTH_RESET = 5;

  typedef enum logic [REG_INDEX_WIDTH-1:0] {
    REG_BAND_WIDTH     = 3'd0,
    REG_BAND_HEIGHT    = 3'd1,
    REG_TILE_WIDTH     = 3'd2,
    REG_TILE_HEIGHT    = 3'd3,
    REG_WINDOW_RANGE   = 3'd4,
    REG_WINDOW_AZIMUTH = 3'd5
  } otwg_reg_e;

  typedef logic [1:0] otwg_status_t;
  localparam otwg_status_t STATUS_OK        = 2'd0;
  localparam otwg_status_t STATUS_WIN_LARGE = 2'd1;
  localparam otwg_status_t STATUS_BEYOND    = 2'd2;

  // Load strobes for the three datapath stages.
  typedef struct packed {
    logic ld1;
    logic ld2;
    logic ld3;
  } otwg_stage_en_t;

endpackage

// ----- src/overlap_tile_window_generator.sv -----
// A transaction passes the stage 1, stage 2 and stage 3 registers; the x descriptor is sent first, y after it is taken.
// Each tile gives two output transactions, and these set the rate at which input transactions are taken.
// A new input transaction is taken while the previous pair still waits at the output.
// Reset (rst, synchronous, active high) empties all stages and loads default register values.
// Configuration is to be written only while no transaction is in flight; the block does not enforce this.
module overlap_tile_window_generator #(
  parameter int DIM_WIDTH = otwg_pkg::DIM_WIDTH_DEF,
  parameter int WIN_WIDTH = otwg_pkg::WIN_WIDTH_DEF
) (
  input  logic                                         clk,
  input  logic                                         rst,
  input  logic                                         cfg_write,
  input  logic [otwg_pkg::REG_INDEX_WIDTH-1:0]         cfg_index,
  input  logic [((DIM_WIDTH > WIN_WIDTH) ? DIM_WIDTH : WIN_WIDTH)-1:0] cfg_data,
  input  logic                                         in_valid,
  output logic                                         in_stall,
  input  logic [DIM_WIDTH-1:0]                         tile_col,
  input  logic [DIM_WIDTH-1:0]                         tile_row,
  output logic                                         out_valid,
  input  logic                                         out_stall,
  output logic                                         axis,
  output logic [DIM_WIDTH:0]                           region_start,
  output logic [DIM_WIDTH:0]                           region_end,
  output logic [DIM_WIDTH-1:0]                         core_start,
  output logic [DIM_WIDTH-1:0]                         core_end,
  output logic [WIN_WIDTH-2:0]                         pad_before,
  output logic [WIN_WIDTH-1:0]                         pad_after,
  output logic [1:0]                                   status,
  output logic                                         final_result
);
  import otwg_pkg::*;

  logic [DIM_WIDTH-1:0] band_width, band_height, tile_width, tile_height;
  logic [WIN_WIDTH-1:0] window_range, window_azimuth;

  otwg_cfg #(.DIM_WIDTH(DIM_WIDTH), .WIN_WIDTH(WIN_WIDTH)) u_cfg (
    .clk            (clk),
    .rst            (rst),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .band_width     (band_width),
    .band_height    (band_height),
    .tile_width     (tile_width),
    .tile_height    (tile_height),
    .window_range   (window_range),
    .window_azimuth (window_azimuth)
  );

  // Pipeline control. Stage 1 multiplies, stage 2 compares against the band
  // and forms the raw bounds, stage 3 applies the tile case and the status.
  // Each stage loads when it is empty or when the stage after it moves on, so
  // bubbles collapse and a stall at the output backs up without loss.
  logic           v1, v2;
  logic           rdy1, rdy2, rdy3;
  otwg_stage_en_t en;

  assign rdy2     = !v2 || rdy3;
  assign rdy1     = !v1 || rdy2;
  assign in_stall = !rdy1;
  assign en.ld1   = in_valid && rdy1;
  assign en.ld2   = v1 && rdy2;
  assign en.ld3   = v2 && rdy3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      if (rdy1) begin
        v1 <= in_valid;
      end
      if (rdy2) begin
        v2 <= v1;
      end
    end
  end

  // Status is shared by both descriptors: a too large window on either axis
  // wins over an index beyond the band on either axis.
  logic         x_large, y_large, x_beyond, y_beyond;
  otwg_status_t status_s2;

  always_comb begin
    if (x_large || y_large) begin
      status_s2 = STATUS_WIN_LARGE;
    end else if (x_beyond || y_beyond) begin
      status_s2 = STATUS_BEYOND;
    end else begin
      status_s2 = STATUS_OK;
    end
  end

  logic [DIM_WIDTH:0]   x_rs, x_re, y_rs, y_re;
  logic [DIM_WIDTH-1:0] x_cs, x_ce, y_cs, y_ce;
  logic [WIN_WIDTH-2:0] x_pb, y_pb;
  logic [WIN_WIDTH-1:0] x_pa, y_pa;

  otwg_axis #(.DIM_WIDTH(DIM_WIDTH), .WIN_WIDTH(WIN_WIDTH)) u_axis_x (
    .clk          (clk),
    .en           (en),
    .idx          (tile_col),
    .band         (band_width),
    .tile         (tile_width),
    .win          (window_range),
    .status_ok    (status_s2 == STATUS_OK),
    .win_large    (x_large),
    .beyond       (x_beyond),
    .region_start (x_rs),
    .region_end   (x_re),
    .core_start   (x_cs),
    .core_end     (x_ce),
    .pad_before   (x_pb),
    .pad_after    (x_pa)
  );

  otwg_axis #(.DIM_WIDTH(DIM_WIDTH), .WIN_WIDTH(WIN_WIDTH)) u_axis_y (
    .clk          (clk),
    .en           (en),
    .idx          (tile_row),
    .band         (band_height),
    .tile         (tile_height),
    .win          (window_azimuth),
    .status_ok    (status_s2 == STATUS_OK),
    .win_large    (y_large),
    .beyond       (y_beyond),
    .region_start (y_rs),
    .region_end   (y_re),
    .core_start   (y_cs),
    .core_end     (y_ce),
    .pad_before   (y_pb),
    .pad_after    (y_pa)
  );

  // The stage 3 registers of both axes form the output pair; the serializer
  // sends the x descriptor and then the y descriptor from it.
  otwg_out_ser #(.DIM_WIDTH(DIM_WIDTH), .WIN_WIDTH(WIN_WIDTH)) u_out (
    .clk            (clk),
    .rst            (rst),
    .s2_valid       (v2),
    .status_in      (status_s2),
    .pair_ready     (rdy3),
    .x_region_start (x_rs),
    .x_region_end   (x_re),
    .x_core_start   (x_cs),
    .x_core_end     (x_ce),
    .x_pad_before   (x_pb),
    .x_pad_after    (x_pa),
    .y_region_start (y_rs),
    .y_region_end   (y_re),
    .y_core_start   (y_cs),
    .y_core_end     (y_ce),
    .y_pad_before   (y_pb),
    .y_pad_after    (y_pa),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .axis           (axis),
    .region_start   (region_start),
    .region_end     (region_end),
    .core_start     (core_start),
    .core_end       (core_end),
    .pad_before     (pad_before),
    .pad_after      (pad_after),
    .status         (status),
    .final_result   (final_result)
  );

endmodule

// ----- src/otwg_cfg.sv -----
// Configuration register file of the tile window generator.
module otwg_cfg #(
  parameter int DIM_WIDTH = otwg_pkg::DIM_WIDTH_DEF,
  parameter int WIN_WIDTH = otwg_pkg::WIN_WIDTH_DEF,
  parameter int CFG_WIDTH = (DIM_WIDTH > WIN_WIDTH) ? DIM_WIDTH : WIN_WIDTH
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_write,
  input  logic [otwg_pkg::REG_INDEX_WIDTH-1:0]  cfg_index,
  input  logic [CFG_WIDTH-1:0]                  cfg_data,
  output logic [DIM_WIDTH-1:0]                  band_width,
  output logic [DIM_WIDTH-1:0]                  band_height,
  output logic [DIM_WIDTH-1:0]                  tile_width,
  output logic [DIM_WIDTH-1:0]                  tile_height,
  output logic [WIN_WIDTH-1:0]                  window_range,
  output logic [WIN_WIDTH-1:0]                  window_azimuth
);
  import otwg_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      band_width     <= DIM_WIDTH'(BAND_WIDTH_RESET);
      band_height    <= DIM_WIDTH'(BAND_HEIGHT_RESET);
      tile_width     <= DIM_WIDTH'(TILE_WIDTH_RESET);
      tile_height    <= DIM_WIDTH'(TILE_HEIGHT_RESET);
      window_range   <= WIN_WIDTH'(WINDOW_RANGE_RESET);
      window_azimuth <= WIN_WIDTH'(WINDOW_AZIMUTH_RESET);
    end else if (cfg_write) begin
      case (otwg_reg_e'(cfg_index))
        REG_BAND_WIDTH:     band_width     <= cfg_data[DIM_WIDTH-1:0];
        REG_BAND_HEIGHT:    band_height    <= cfg_data[DIM_WIDTH-1:0];
        REG_TILE_WIDTH:     tile_width     <= cfg_data[DIM_WIDTH-1:0];
        REG_TILE_HEIGHT:    tile_height    <= cfg_data[DIM_WIDTH-1:0];
        REG_WINDOW_RANGE:   window_range   <= cfg_data[WIN_WIDTH-1:0];
        REG_WINDOW_AZIMUTH: window_azimuth <= cfg_data[WIN_WIDTH-1:0];
        default: ;
      endcase
    end
  end

endmodule

// ----- src/otwg_axis.sv -----
// Three-stage datapath that builds the descriptor of one axis.
module otwg_axis #(
  parameter int DIM_WIDTH = otwg_pkg::DIM_WIDTH_DEF,
  parameter int WIN_WIDTH = otwg_pkg::WIN_WIDTH_DEF
) (
  input  logic                         clk,
  input  otwg_pkg::otwg_stage_en_t     en,
  input  logic [DIM_WIDTH-1:0]         idx,
  input  logic [DIM_WIDTH-1:0]         band,
  input  logic [DIM_WIDTH-1:0]         tile,
  input  logic [WIN_WIDTH-1:0]         win,
  input  logic                         status_ok,
  output logic                         win_large,
  output logic                         beyond,
  output logic [DIM_WIDTH:0]           region_start,
  output logic [DIM_WIDTH:0]           region_end,
  output logic [DIM_WIDTH-1:0]         core_start,
  output logic [DIM_WIDTH-1:0]         core_end,
  output logic [WIN_WIDTH-2:0]         pad_before,
  output logic [WIN_WIDTH-1:0]         pad_after
);
  import otwg_pkg::*;

  localparam int PW = 2 * DIM_WIDTH;
  localparam int CW = ((DIM_WIDTH > WIN_WIDTH) ? DIM_WIDTH : WIN_WIDTH) + 1;

  logic [WIN_WIDTH-1:0] half_full;
  logic [WIN_WIDTH-2:0] half;
  logic                 asym;
  logic [WIN_WIDTH-1:0] half_asym;
  logic [PW:0]          p1;

  // Stage 1: the product idx * tile.
  logic              idx_zero1;
  logic [PW-1:0]     p0_1;
  // Stage 2: range checks and the raw region bounds.
  logic              idx_zero2;
  logic              last2;
  logic [DIM_WIDTH-1:0] cs2;
  logic [DIM_WIDTH:0]   rs2;
  logic [DIM_WIDTH:0]   re2;
  logic [DIM_WIDTH-1:0] ce2;

  // A window of zero counts as half zero with one extra pixel after.
  assign half_full = (win == '0) ? ((win - WIN_WIDTH'(1)) >> 1) & '0 : (win - WIN_WIDTH'(1)) >> 1;
  assign half      = half_full[WIN_WIDTH-2:0];
  assign asym      = ~win[0];
  assign half_asym = {1'b0, half} + WIN_WIDTH'(asym);
  assign p1        = {1'b0, p0_1} + (PW+1)'(tile);

  always_ff @(posedge clk) begin
    if (en.ld1) begin
      idx_zero1 <= (idx == '0);
      p0_1      <= PW'(idx) * PW'(tile);
    end
    if (en.ld2) begin
      idx_zero2 <= idx_zero1;
      win_large <= (tile == '0) || (CW'({half, 1'b0}) > CW'(tile));
      beyond    <= (p0_1 >= PW'(band));
      last2     <= (p1 >= (PW+1)'(band));
      cs2       <= p0_1[DIM_WIDTH-1:0];
      rs2       <= p0_1[DIM_WIDTH:0] - (DIM_WIDTH+1)'(half);
      re2       <= p1[DIM_WIDTH:0] - (DIM_WIDTH+1)'(1) + (DIM_WIDTH+1)'(half_asym);
      ce2       <= p1[DIM_WIDTH-1:0] - DIM_WIDTH'(1);
    end
    if (en.ld3) begin
      if (status_ok) begin
        region_start <= idx_zero2 ? '0 : rs2;
        region_end   <= last2 ? ({1'b0, band} - (DIM_WIDTH+1)'(1)) : re2;
        core_start   <= cs2;
        core_end     <= last2 ? (band - DIM_WIDTH'(1)) : ce2;
        pad_before   <= idx_zero2 ? half : '0;
        pad_after    <= last2 ? half_asym : '0;
      end else begin
        region_start <= '0;
        region_end   <= '0;
        core_start   <= '0;
        core_end     <= '0;
        pad_before   <= '0;
        pad_after    <= '0;
      end
    end
  end

endmodule

// ----- src/otwg_out_ser.sv -----
// Output stage: selects from a descriptor pair and sends the x then the y descriptor.
module otwg_out_ser #(
  parameter int DIM_WIDTH = otwg_pkg::DIM_WIDTH_DEF,
  parameter int WIN_WIDTH = otwg_pkg::WIN_WIDTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s2_valid,
  input  otwg_pkg::otwg_status_t     status_in,
  output logic                       pair_ready,
  input  logic [DIM_WIDTH:0]         x_region_start,
  input  logic [DIM_WIDTH:0]         x_region_end,
  input  logic [DIM_WIDTH-1:0]       x_core_start,
  input  logic [DIM_WIDTH-1:0]       x_core_end,
  input  logic [WIN_WIDTH-2:0]       x_pad_before,
  input  logic [WIN_WIDTH-1:0]       x_pad_after,
  input  logic [DIM_WIDTH:0]         y_region_start,
  input  logic [DIM_WIDTH:0]         y_region_end,
  input  logic [DIM_WIDTH-1:0]       y_core_start,
  input  logic [DIM_WIDTH-1:0]       y_core_end,
  input  logic [WIN_WIDTH-2:0]       y_pad_before,
  input  logic [WIN_WIDTH-1:0]       y_pad_after,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic                       axis,
  output logic [DIM_WIDTH:0]         region_start,
  output logic [DIM_WIDTH:0]         region_end,
  output logic [DIM_WIDTH-1:0]       core_start,
  output logic [DIM_WIDTH-1:0]       core_end,
  output logic [WIN_WIDTH-2:0]       pad_before,
  output logic [WIN_WIDTH-1:0]       pad_after,
  output logic [1:0]                 status,
  output logic                       final_result
);
  import otwg_pkg::*;

  logic         sel;
  logic         load;
  logic         out_take;
  otwg_status_t status_reg;

  assign out_take   = out_valid && !out_stall;
  assign pair_ready = !out_valid || (out_take && sel);
  assign load       = s2_valid && pair_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      sel       <= 1'b0;
    end else begin
      if (pair_ready) begin
        out_valid <= s2_valid;
      end
      if (load) begin
        sel <= 1'b0;
      end else if (out_take) begin
        sel <= ~sel;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      status_reg <= status_in;
    end
  end

  assign axis         = sel;
  assign final_result = sel;
  assign status       = status_reg;
  assign region_start = sel ? y_region_start : x_region_start;
  assign region_end   = sel ? y_region_end   : x_region_end;
  assign core_start   = sel ? y_core_start   : x_core_start;
  assign core_end     = sel ? y_core_end     : x_core_end;
  assign pad_before   = sel ? y_pad_before   : x_pad_before;
  assign pad_after    = sel ? y_pad_after    : x_pad_after;

endmodule

// ----- src/otwg_checker.sv -----
// Port-level checks of the tile window generator and the bind that attaches them.
module otwg_checker #(
  parameter int DIM_WIDTH = otwg_pkg::DIM_WIDTH_DEF,
  parameter int WIN_WIDTH = otwg_pkg::WIN_WIDTH_DEF
) (
  input logic                 clk,
  input logic                 rst,
  input logic                 out_valid,
  input logic                 out_stall,
  input logic                 axis,
  input logic                 final_result,
  input logic [1:0]           status,
  input logic [DIM_WIDTH:0]   region_start,
  input logic [DIM_WIDTH:0]   region_end,
  input logic [DIM_WIDTH-1:0] core_start,
  input logic [DIM_WIDTH-1:0] core_end,
  input logic [WIN_WIDTH-2:0] pad_before,
  input logic [WIN_WIDTH-1:0] pad_after
);
  import otwg_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("output transaction dropped while stalled");

  a_y_follows_x: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !final_result |=> out_valid && final_result)
    else $error("y descriptor does not follow x descriptor");

  a_axis_final: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> axis == final_result)
    else $error("axis and final_result disagree");

  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != STATUS_OK |-> region_start == '0 && region_end == '0 &&
      core_start == '0 && core_end == '0 && pad_before == '0 && pad_after == '0)
    else $error("error descriptor carries nonzero fields");

endmodule

bind overlap_tile_window_generator otwg_checker #(
  .DIM_WIDTH(DIM_WIDTH),
  .WIN_WIDTH(WIN_WIDTH)
) u_otwg_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .axis         (axis),
  .final_result (final_result),
  .status       (status),
  .region_start (region_start),
  .region_end   (region_end),
  .core_start   (core_start),
  .core_end     (core_end),
  .pad_before   (pad_before),
  .pad_after    (pad_after)
);
